>>> design/qfts_pkg.sv
// ----------------------------------------------------------------------------
// qfts_pkg: shared definitions for the two-stack queue
// Stack geometry, element type, action codes and result status codes.
// ----------------------------------------------------------------------------
package qfts_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int TOT_W       = $clog2(2 * STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic [IDX_W-1:0]         idx_t;

    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_DISP = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

>>> design/qfts_stack_ram.sv
// ----------------------------------------------------------------------------
// qfts_stack_ram: storage for one stack
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qfts_stack_ram
    import qfts_pkg::*;
(
    input  logic  clk,
    input  logic  wr_en,
    input  idx_t  wr_addr,
    input  elem_t wr_data,
    input  logic  rd_en,
    input  idx_t  rd_addr,
    output elem_t rd_data
);

    elem_t mem [STACK_DEPTH];
    elem_t rd_data_reg;

    // Write the addressed entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read; hold the last value when no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/queue_from_two_stacks_core.sv
// ----------------------------------------------------------------------------
// queue_from_two_stacks_core: FIFO queue built from two stacks
// Enqueue pushes onto the inbound stack; dequeue pops the outbound stack,
// refilling it from the inbound stack when it runs dry; display streams the
// whole queue front first.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Direction  Role
//  -------   -------------------------------  ---------  --------------------
//  req       req_valid req_stall action value in         one operation item
//  rsp       rsp_valid rsp_stall data status  out        result items,
//            last                                        last marks final one
//
//  Enqueue and every empty / full report are accepted, then emitted.
//  Dequeue accepts, reads the outbound top, then emits; each element moved
//  on a refill is read, then written. The stack RAM's registered read port
//  sets these steps. Display accepts, then reads and emits each element.
//  Reset clears both counts and the sequencer; stack contents need no clear.
//  A stalled result holds in the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module queue_from_two_stacks_core
    import qfts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  action,
    input  elem_t       value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output elem_t       data,
    output logic [1:0]  status,
    output logic        last
);

    // Sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EMIT      = 3'd1;
    localparam logic [2:0] S_XFER_RD   = 3'd2;
    localparam logic [2:0] S_XFER_WR   = 3'd3;
    localparam logic [2:0] S_POP_RD    = 3'd4;
    localparam logic [2:0] S_POP_EMIT  = 3'd5;
    localparam logic [2:0] S_DISP_RD   = 3'd6;
    localparam logic [2:0] S_DISP_EMIT = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] ic_reg, ic_next;        // inbound stack fill
    logic [CNT_W-1:0] oc_reg, oc_next;        // outbound stack fill
    logic [TOT_W-1:0] n_reg, n_next;          // display position
    logic             src_reg, src_next;      // display source: 1 = inbound
    elem_t            res_data_reg, res_data_next;
    logic [1:0]       res_status_reg, res_status_next;

    logic             rsp_valid_reg, rsp_valid_next;
    elem_t            data_reg, data_next;
    logic [1:0]       status_reg, status_next;
    logic             last_reg, last_next;

    // Stack RAM ports
    logic  in_wr_en, in_rd_en, ob_wr_en, ob_rd_en;
    idx_t  in_wr_addr, in_rd_addr, ob_wr_addr, ob_rd_addr;
    elem_t in_rd_data, ob_rd_data;

    logic [CNT_W-1:0] ic_dec, oc_dec, oc_inc;
    logic [TOT_W-1:0] total, disp_ob_idx, disp_in_idx, n_inc;
    logic             rsp_free;

    assign ic_dec      = ic_reg - CNT_W'(1);
    assign oc_dec      = oc_reg - CNT_W'(1);
    assign oc_inc      = oc_reg + CNT_W'(1);
    assign total       = TOT_W'(ic_reg) + TOT_W'(oc_reg);
    assign n_inc       = n_reg + TOT_W'(1);
    // Outbound stack is read top down, then the inbound stack bottom up.
    assign disp_ob_idx = TOT_W'(oc_reg) - n_reg - TOT_W'(1);
    assign disp_in_idx = n_reg - TOT_W'(oc_reg);

    // The output register can take a new result this cycle.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);

    qfts_stack_ram u_inbound
    (
        .clk     (clk),
        .wr_en   (in_wr_en),
        .wr_addr (in_wr_addr),
        .wr_data (value),
        .rd_en   (in_rd_en),
        .rd_addr (in_rd_addr),
        .rd_data (in_rd_data)
    );

    qfts_stack_ram u_outbound
    (
        .clk     (clk),
        .wr_en   (ob_wr_en),
        .wr_addr (ob_wr_addr),
        .wr_data (in_rd_data),
        .rd_en   (ob_rd_en),
        .rd_addr (ob_rd_addr),
        .rd_data (ob_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        ic_next         = ic_reg;
        oc_next         = oc_reg;
        n_next          = n_reg;
        src_next        = src_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg;
        data_next       = data_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        in_wr_en   = 1'b0;
        in_wr_addr = ic_reg[IDX_W-1:0];
        in_rd_en   = 1'b0;
        in_rd_addr = ic_dec[IDX_W-1:0];
        ob_wr_en   = 1'b0;
        ob_wr_addr = oc_reg[IDX_W-1:0];
        ob_rd_en   = 1'b0;
        ob_rd_addr = oc_dec[IDX_W-1:0];

        // Drop the held result once the consumer takes it.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (action)
                        ACT_ENQ:
                        begin
                            if (ic_reg == CNT_W'(STACK_DEPTH))
                            begin
                                res_data_next   = '0;
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                in_wr_en        = 1'b1;
                                ic_next         = ic_reg + CNT_W'(1);
                                res_data_next   = value;
                                res_status_next = ST_OK;
                            end
                            state_next = S_EMIT;
                        end
                        ACT_DEQ:
                        begin
                            if (oc_reg != '0)
                            begin
                                state_next = S_POP_RD;
                            end
                            else if (ic_reg != '0)
                            begin
                                state_next = S_XFER_RD;
                            end
                            else
                            begin
                                res_data_next   = '0;
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                        end
                        ACT_DISP:
                        begin
                            if (total == '0)
                            begin
                                res_data_next   = '0;
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                n_next     = '0;
                                state_next = S_DISP_RD;
                            end
                        end
                        default:
                        begin
                            // Unused code: no result, state unchanged.
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    data_next      = res_data_reg;
                    status_next    = res_status_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_XFER_RD:
            begin
                in_rd_en   = 1'b1;
                ic_next    = ic_dec;
                state_next = S_XFER_WR;
            end
            S_XFER_WR:
            begin
                ob_wr_en = 1'b1;
                oc_next  = oc_inc;
                if (ic_reg == '0 || oc_inc == CNT_W'(STACK_DEPTH))
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    state_next = S_XFER_RD;
                end
            end
            S_POP_RD:
            begin
                ob_rd_en   = 1'b1;
                oc_next    = oc_dec;
                state_next = S_POP_EMIT;
            end
            S_POP_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    data_next      = ob_rd_data;
                    status_next    = ST_OK;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DISP_RD:
            begin
                if (n_reg < TOT_W'(oc_reg))
                begin
                    ob_rd_en   = 1'b1;
                    ob_rd_addr = disp_ob_idx[IDX_W-1:0];
                    src_next   = 1'b0;
                end
                else
                begin
                    in_rd_en   = 1'b1;
                    in_rd_addr = disp_in_idx[IDX_W-1:0];
                    src_next   = 1'b1;
                end
                state_next = S_DISP_EMIT;
            end
            S_DISP_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    data_next      = src_reg ? in_rd_data : ob_rd_data;
                    status_next    = ST_OK;
                    last_next      = (n_inc == total);
                    if (n_inc == total)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        n_next     = n_inc;
                        state_next = S_DISP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ic_reg        <= '0;
            oc_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ic_reg        <= ic_next;
            oc_reg        <= oc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        src_reg        <= src_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        data_reg       <= data_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: two-stack queue core
// Drives enqueue, dequeue, display and unused-code items with random gaps
// and result stalls. A software copy of both stacks predicts every result
// item, and the monitor checks them in order.
// ----------------------------------------------------------------------------
module testbench;
    import qfts_pkg::*;

    // Action code three has no meaning to the core and must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 400;
    // Idle the outputs long enough for a full refill to finish after the end.
    localparam int DRAIN_CYCLES = 60;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    // Window of cycles in which neither side takes a break.
    localparam int STEADY_FROM  = 800;
    localparam int STEADY_TO    = 1600;

    typedef struct packed {
        logic [1:0] action;
        elem_t      value;
    } op_t;

    typedef struct packed {
        elem_t      data;
        logic [1:0] status;
        logic       last;
    } result_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       req_valid   = 1'b0;
    logic       req_stall;
    logic [1:0] action      = ACT_ENQ;
    elem_t      value       = '0;
    logic       rsp_valid;
    logic       rsp_stall   = 1'b0;
    elem_t      data;
    logic [1:0] status;
    logic       last;

    queue_from_two_stacks_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .action    (action),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .data      (data),
        .status    (status),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Queue predictor: own copy of both stacks and their fill levels
    // ------------------------------------------------------------------
    elem_t   inbound_model  [STACK_DEPTH];
    elem_t   outbound_model [STACK_DEPTH];
    int      inbound_fill   = 0;
    int      outbound_fill  = 0;
    result_t expected_results[$];
    op_t     pending_ops[$];

    int      mismatch_count = 0;
    int      cycle_count    = 0;
    logic    req_fire       = 1'b0;

    function automatic void expect_result(elem_t d, logic [1:0] st, logic lst);
        result_t r;
        r.data   = d;
        r.status = st;
        r.last   = lst;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted item to the predicted queue and queue its results.
    function automatic void queue_apply(logic [1:0] op, elem_t item);
        int total;
        int n;
        n = 0;
        case (op)
            ACT_ENQ:
            begin
                if (inbound_fill >= STACK_DEPTH)
                begin
                    // Drop the insert, report full, leave the queue alone.
                    expect_result('0, ST_FULL, 1'b1);
                end
                else
                begin
                    inbound_model[inbound_fill] = item;
                    inbound_fill++;
                    expect_result(item, ST_OK, 1'b1);
                end
            end
            ACT_DEQ:
            begin
                if (outbound_fill == 0 && inbound_fill == 0)
                    expect_result('0, ST_EMPTY, 1'b1);
                else
                begin
                    // Refill the outbound stack only once it has run dry;
                    // the move reverses the order, which puts the oldest on top.
                    if (outbound_fill == 0)
                    begin
                        while (inbound_fill > 0 && outbound_fill < STACK_DEPTH)
                        begin
                            inbound_fill--;
                            outbound_model[outbound_fill] = inbound_model[inbound_fill];
                            outbound_fill++;
                        end
                    end
                    outbound_fill--;
                    expect_result(outbound_model[outbound_fill], ST_OK, 1'b1);
                end
            end
            ACT_DISP:
            begin
                total = inbound_fill + outbound_fill;
                if (total == 0)
                    expect_result('0, ST_EMPTY, 1'b1);
                else
                begin
                    // Front first: outbound from its top down, then inbound
                    // from its bottom up.
                    for (int i = outbound_fill - 1; i >= 0; i--)
                    begin
                        n++;
                        expect_result(outbound_model[i], ST_OK, n == total);
                    end
                    for (int i = 0; i < inbound_fill; i++)
                    begin
                        n++;
                        expect_result(inbound_model[i], ST_OK, n == total);
                    end
                end
            end
            default:
            begin
                // Unused code: no result, no state change.
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Idle pattern shared by both sides
    // ------------------------------------------------------------------
    function automatic logic take_break();
        if (cycle_count >= STEADY_FROM && cycle_count < STEADY_TO)
            return 1'b0;
        return $urandom_range(99) < 22;
    endfunction

    function automatic elem_t pick_value();
        // Hit the extremes now and then; otherwise any 32-bit pattern.
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return -1;
            3: return 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [1:0] op, elem_t item);
        op_t o;
        o.action = op;
        o.value  = item;
        pending_ops.push_back(o);
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge only.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic next_valid;
        op_t  next_op;
        next_valid = req_valid;
        // Drop the item that the core took at the last rising edge.
        if (req_valid && req_fire)
            next_valid = 1'b0;
        // Advance to the next item unless this cycle is a break; hold
        // a stalled item as it is.
        if (rst_n && !next_valid && pending_ops.size() != 0 && !take_break())
        begin
            next_op   = pending_ops.pop_front();
            action    <= next_op.action;
            value     <= next_op.value;
            next_valid = 1'b1;
        end
        req_valid <= next_valid;
        rsp_stall <= rst_n ? take_break() : 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        cycle_count++;
        req_fire <= req_valid && !req_stall;

        if (req_valid && !req_stall)
            queue_apply(action, value);

        if (rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", data, '0);
            else
            begin
                want = expected_results.pop_front();
                if (data !== want.data)
                    report_mismatch("data", data, want.data);
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no handshake happens for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int         issued;
        int         mode;
        int         roll;
        int         burst;
        logic [1:0] act;

        // Directed part: empty queue, unused code, fill to the brim with the
        // extremes, overflow, full display, refill on dequeue, mixed display.
        add_op(ACT_DISP, 32'h1234_5678);
        add_op(ACT_DEQ, -1);
        add_op(ACT_UNUSED, 32'hFFFF_FFFF);
        add_op(ACT_ENQ, 32'h7FFF_FFFF);
        add_op(ACT_ENQ, 32'h8000_0000);
        add_op(ACT_ENQ, -1);
        add_op(ACT_ENQ, 0);
        add_op(ACT_ENQ, 19);
        for (int i = 0; i < STACK_DEPTH - 5; i++)
            add_op(ACT_ENQ, $urandom);
        add_op(ACT_ENQ, 32'h5555_5555);
        add_op(ACT_DISP, 0);
        add_op(ACT_DEQ, 0);
        add_op(ACT_ENQ, 32'hAAAA_AAAA);
        add_op(ACT_DISP, -1);
        add_op(ACT_DEQ, 32'h8000_0000);

        // Random part: bursts that lean toward filling, draining or neither,
        // so the queue sweeps between empty and full many times.
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            mode  = $urandom_range(2);
            burst = $urandom_range(30, 8);
            repeat (burst)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    add_op(ACT_UNUSED, $urandom);
                else
                begin
                    if (roll < 11)
                        act = ACT_DISP;
                    else if (mode == 0)
                        act = (roll < 75) ? ACT_ENQ : ACT_DEQ;
                    else if (mode == 1)
                        act = (roll < 35) ? ACT_ENQ : ACT_DEQ;
                    else
                        act = (roll < 55) ? ACT_ENQ : ACT_DEQ;
                    add_op(act, pick_value());
                    issued++;
                end
            end
        end

        // Hold reset, then release it away from the rising edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to go in and every result to come out.
        while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
